// ----- rtl/core/dbot_pkg.sv -----
// Shared definitions for the depth-bucket ordering table: defaults, field widths,
// opcodes, controller states and the command/status records between the two halves.
// No dependencies.
package dbot_pkg;

    localparam int DEF_DEPTH_BUCKETS = 1024;
    localparam int DEF_MAX_FACES     = 4096;
    localparam int DEF_MAX_VERTICES  = 4096;

    localparam int DEPTH_W  = 16;
    localparam int DSUM_W   = DEPTH_W + 1;
    localparam int INDEX_W  = 12;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 13;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_INSERT  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_FETCH   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_INSERT,
        ST_ADVANCE,
        ST_HEAD,
        ST_STEP,
        ST_FACE
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_PLAIN,
        EMIT_INSERT,
        EMIT_ADVANCE,
        EMIT_FACE,
        EMIT_DRAINED
    } emit_t;

    typedef enum logic {
        HEAD_AT_CALC,
        HEAD_AT_DRAIN
    } head_sel_t;

    typedef struct packed {
        logic      latch;
        logic      head_rd;
        head_sel_t head_sel;
        logic      fetch_begin;
        logic      sweep_start;
        logic      sweep_step;
        logic      ins_commit;
        logic      adv_commit;
        logic      load_head;
        logic      face_rd;
        logic      bucket_dec;
        logic      load_face;
        logic      drain_done;
        emit_t     emit;
    } dbot_cmd_t;

    typedef struct packed {
        logic drain_started;
        logic entry_ok;
        logic bucket_zero;
        logic sweep_last;
        logic face_textured;
    } dbot_status_t;

endpackage

// ----- rtl/core/depth_bucket_ordering_table.sv -----
// Top level of the depth-bucket ordering table (painter's-order face sorter).
// Depends on dbot_pkg, dbot_ctrl and dbot_dp.
//
// Items are taken when start is high and busy is low; each item yields exactly one
// result, shown for one cycle with done high, and the receiver cannot stall it, so
// sample the result ports whenever done is high. Opcode 0 clears the table, 1 inserts
// a face into the bucket ((depth_a+depth_b)*DEPTH_BUCKETS)>>17 (dropped with overflow
// when the face store is full or a rebased vertex index is past the vertex range),
// 2 advances the vertex base, 3 returns the next textured face, farthest bucket
// first and newest face first within a bucket, or drained once bucket 0 is passed.
// An insert is one bucket-head read, then the write-back. A clear runs a sweep
// that empties the bucket-head memory one entry per cycle; the same sweep runs
// after reset, with busy high. A fetch is a walk in which every step is one
// registered read of the head memory or of the face store.
module depth_bucket_ordering_table
    import dbot_pkg::*;
#(
    parameter int DEPTH_BUCKETS = DEF_DEPTH_BUCKETS,
    parameter int MAX_FACES     = DEF_MAX_FACES,
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [DEPTH_W-1:0]  depth_a,
    input  logic [DEPTH_W-1:0]  depth_b,
    input  logic [INDEX_W-1:0]  index_a,
    input  logic [INDEX_W-1:0]  index_b,
    input  logic [INDEX_W-1:0]  index_c,
    input  logic                textured,
    input  logic [HANDLE_W-1:0] texture_handle,
    input  logic [COUNT_W-1:0]  vertex_count,
    output logic                done,
    output logic                face_valid,
    output logic [INDEX_W-1:0]  vertex_a,
    output logic [INDEX_W-1:0]  vertex_b,
    output logic [INDEX_W-1:0]  vertex_c,
    output logic [HANDLE_W-1:0] texture_out,
    output logic                drained,
    output logic                overflow
);

    // Commands flow from the sequencer to the datapath; status flows back.
    dbot_cmd_t    cmd;
    dbot_status_t status;

    // Sequencer: decodes the opcode on accept and walks the buckets on fetch.
    dbot_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: head and face memories, counters, drain cursor, result registers.
    dbot_dp #(
        .DEPTH_BUCKETS (DEPTH_BUCKETS),
        .MAX_FACES     (MAX_FACES),
        .MAX_VERTICES  (MAX_VERTICES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .depth_a        (depth_a),
        .depth_b        (depth_b),
        .index_a        (index_a),
        .index_b        (index_b),
        .index_c        (index_c),
        .textured       (textured),
        .texture_handle (texture_handle),
        .vertex_count   (vertex_count),
        .done           (done),
        .face_valid     (face_valid),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .vertex_c       (vertex_c),
        .texture_out    (texture_out),
        .drained        (drained),
        .overflow       (overflow)
    );

endmodule

// ----- rtl/core/dbot_ctrl.sv -----
// Sequencer of the depth-bucket ordering table: accepts items and steps the datapath.
// Depends on dbot_pkg.
module dbot_ctrl
    import dbot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   opcode,
    input  dbot_status_t status,
    output dbot_cmd_t    cmd,
    output logic         busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    unique case (opcode_t'(opcode))
                        OP_CLEAR:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        OP_INSERT:
                        begin
                            cmd.head_rd  = 1'b1;
                            cmd.head_sel = HEAD_AT_CALC;
                            state_next   = ST_INSERT;
                        end
                        OP_ADVANCE:
                        begin
                            state_next = ST_ADVANCE;
                        end
                        OP_FETCH:
                        begin
                            if (!status.drain_started)
                            begin
                                cmd.fetch_begin = 1'b1;
                                cmd.head_rd     = 1'b1;
                                cmd.head_sel    = HEAD_AT_DRAIN;
                                state_next      = ST_HEAD;
                            end
                            else
                            begin
                                state_next = ST_STEP;
                            end
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.emit   = EMIT_PLAIN;
                    state_next = ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                cmd.ins_commit = 1'b1;
                cmd.emit       = EMIT_INSERT;
                state_next     = ST_IDLE;
            end
            ST_ADVANCE:
            begin
                cmd.adv_commit = 1'b1;
                cmd.emit       = EMIT_ADVANCE;
                state_next     = ST_IDLE;
            end
            ST_HEAD:
            begin
                cmd.load_head = 1'b1;
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.entry_ok)
                begin
                    cmd.face_rd = 1'b1;
                    state_next  = ST_FACE;
                end
                else if (status.bucket_zero)
                begin
                    cmd.drain_done = 1'b1;
                    cmd.emit       = EMIT_DRAINED;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.bucket_dec = 1'b1;
                    cmd.head_rd    = 1'b1;
                    cmd.head_sel   = HEAD_AT_DRAIN;
                    state_next     = ST_HEAD;
                end
            end
            ST_FACE:
            begin
                cmd.load_face = 1'b1;
                if (status.face_textured)
                begin
                    cmd.emit   = EMIT_FACE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
        endcase
    end

endmodule

// ----- rtl/core/dbot_dp.sv -----
// Datapath of the depth-bucket ordering table: bucket heads, face store with links,
// counters, the drain walk and the result registers. Depends on dbot_pkg.
module dbot_dp
    import dbot_pkg::*;
#(
    parameter int DEPTH_BUCKETS = DEF_DEPTH_BUCKETS,
    parameter int MAX_FACES     = DEF_MAX_FACES,
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dbot_cmd_t           cmd,
    output dbot_status_t        status,
    input  logic [DEPTH_W-1:0]  depth_a,
    input  logic [DEPTH_W-1:0]  depth_b,
    input  logic [INDEX_W-1:0]  index_a,
    input  logic [INDEX_W-1:0]  index_b,
    input  logic [INDEX_W-1:0]  index_c,
    input  logic                textured,
    input  logic [HANDLE_W-1:0] texture_handle,
    input  logic [COUNT_W-1:0]  vertex_count,
    output logic                done,
    output logic                face_valid,
    output logic [INDEX_W-1:0]  vertex_a,
    output logic [INDEX_W-1:0]  vertex_b,
    output logic [INDEX_W-1:0]  vertex_c,
    output logic [HANDLE_W-1:0] texture_out,
    output logic                drained,
    output logic                overflow
);

    localparam int BW  = $clog2(DEPTH_BUCKETS);
    localparam int DBW = $clog2(DEPTH_BUCKETS + 1);
    localparam int PW  = DSUM_W + DBW;
    localparam int FW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FCW = $clog2(MAX_FACES + 1);
    localparam int VBW = $clog2(MAX_VERTICES + 1);
    localparam int SW  = ((VBW > INDEX_W) ? VBW : INDEX_W) + 1;
    localparam int AW  = ((VBW > COUNT_W) ? VBW : COUNT_W) + 1;
    localparam int HEW = FW + 1;
    localparam int TEX_BIT = 3 * INDEX_W;
    localparam int HND_LO  = TEX_BIT + 1;
    localparam int LNK_LO  = HND_LO + HANDLE_W;
    localparam int FEW     = LNK_LO + HEW;

    localparam logic [BW-1:0]  BUCKET_TOP  = BW'(DEPTH_BUCKETS - 1);
    localparam logic [DBW-1:0] BUCKET_SAT  = DBW'(DEPTH_BUCKETS - 1);
    localparam logic [PW-1:0]  BUCKET_MUL  = PW'(DEPTH_BUCKETS);
    localparam logic [FCW-1:0] FACE_LIMIT  = FCW'(MAX_FACES);
    localparam logic [SW-1:0]  VERT_LIMIT  = SW'(MAX_VERTICES);
    localparam logic [AW-1:0]  BASE_LIMIT  = AW'(MAX_VERTICES);

    // latched item
    logic [BW-1:0]       bucket_reg;
    logic [INDEX_W-1:0]  index_a_reg;
    logic [INDEX_W-1:0]  index_b_reg;
    logic [INDEX_W-1:0]  index_c_reg;
    logic                textured_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [COUNT_W-1:0]  count_reg;

    // table state
    logic [FCW-1:0] face_count_reg;
    logic [VBW-1:0] vertex_base_reg;
    logic [BW-1:0]  drain_bucket_reg;
    logic [BW-1:0]  drain_bucket_next;
    logic           entry_ok_reg;
    logic [FW-1:0]  drain_entry_reg;
    logic           drain_started_reg;
    logic [BW-1:0]  sweep_reg;

    logic [HEW-1:0] head_mem [DEPTH_BUCKETS];
    logic [HEW-1:0] head_rdata_reg;
    logic [FEW-1:0] face_mem [MAX_FACES];
    logic [FEW-1:0] face_rdata_reg;

    logic [DSUM_W-1:0] dsum;
    logic [PW-1:0]     prod;
    logic [DBW-1:0]    bucket_raw;
    logic [BW-1:0]     bucket_calc;
    logic [BW-1:0]     head_raddr;
    logic              head_we;
    logic [BW-1:0]     head_waddr;
    logic [HEW-1:0]    head_wdata;
    logic              face_we;
    logic [FEW-1:0]    face_wdata;
    logic [SW-1:0]     sum_a;
    logic [SW-1:0]     sum_b;
    logic [SW-1:0]     sum_c;
    logic              ins_ovf;
    logic [AW-1:0]     adv_sum;
    logic              adv_ovf;

    logic                face_valid_next;
    logic [INDEX_W-1:0]  vertex_a_next;
    logic [INDEX_W-1:0]  vertex_b_next;
    logic [INDEX_W-1:0]  vertex_c_next;
    logic [HANDLE_W-1:0] texture_next;
    logic                drained_next;
    logic                overflow_next;

    logic                done_reg;
    logic                face_valid_reg;
    logic [INDEX_W-1:0]  vertex_a_reg;
    logic [INDEX_W-1:0]  vertex_b_reg;
    logic [INDEX_W-1:0]  vertex_c_reg;
    logic [HANDLE_W-1:0] texture_reg;
    logic                drained_reg;
    logic                overflow_reg;

    // bucket = ((a + b) * buckets) >> 17, saturated to the top bucket
    always_comb
    begin
        dsum       = DSUM_W'(depth_a) + DSUM_W'(depth_b);
        prod       = PW'(dsum) * BUCKET_MUL;
        bucket_raw = prod[PW-1:DSUM_W];
        if (bucket_raw > BUCKET_SAT)
        begin
            bucket_calc = BW'(BUCKET_SAT);
        end
        else
        begin
            bucket_calc = bucket_raw[BW-1:0];
        end
    end

    always_comb
    begin
        sum_a   = SW'(index_a_reg) + SW'(vertex_base_reg);
        sum_b   = SW'(index_b_reg) + SW'(vertex_base_reg);
        sum_c   = SW'(index_c_reg) + SW'(vertex_base_reg);
        ins_ovf = (face_count_reg >= FACE_LIMIT) || (sum_a >= VERT_LIMIT)
               || (sum_b >= VERT_LIMIT) || (sum_c >= VERT_LIMIT);
        adv_sum = AW'(vertex_base_reg) + AW'(count_reg);
        adv_ovf = (adv_sum > BASE_LIMIT);
    end

    always_comb
    begin
        drain_bucket_next = drain_bucket_reg;
        if (cmd.sweep_start || cmd.fetch_begin)
        begin
            drain_bucket_next = BUCKET_TOP;
        end
        else if (cmd.bucket_dec)
        begin
            drain_bucket_next = drain_bucket_reg - 1'b1;
        end
        head_raddr = (cmd.head_sel == HEAD_AT_CALC) ? bucket_calc : drain_bucket_next;
    end

    // push the face at the head of its bucket; the old head becomes its link
    always_comb
    begin
        face_we    = cmd.ins_commit && !ins_ovf;
        head_we    = cmd.sweep_step || face_we;
        head_waddr = cmd.sweep_step ? sweep_reg : bucket_reg;
        head_wdata = cmd.sweep_step ? '0 : {1'b1, face_count_reg[FW-1:0]};
        face_wdata = {head_rdata_reg, handle_reg, textured_reg, sum_c[INDEX_W-1:0],
                      sum_b[INDEX_W-1:0], sum_a[INDEX_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (cmd.head_rd)
        begin
            head_rdata_reg <= head_mem[head_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (face_we)
        begin
            face_mem[face_count_reg[FW-1:0]] <= face_wdata;
        end
        if (cmd.face_rd)
        begin
            face_rdata_reg <= face_mem[drain_entry_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            bucket_reg   <= bucket_calc;
            index_a_reg  <= index_a;
            index_b_reg  <= index_b;
            index_c_reg  <= index_c;
            textured_reg <= textured;
            handle_reg   <= texture_handle;
            count_reg    <= vertex_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_count_reg    <= '0;
            vertex_base_reg   <= '0;
            drain_bucket_reg  <= BUCKET_TOP;
            entry_ok_reg      <= 1'b0;
            drain_entry_reg   <= '0;
            drain_started_reg <= 1'b0;
            sweep_reg         <= '0;
        end
        else
        begin
            drain_bucket_reg <= drain_bucket_next;
            if (cmd.sweep_start)
            begin
                face_count_reg    <= '0;
                vertex_base_reg   <= '0;
                entry_ok_reg      <= 1'b0;
                drain_started_reg <= 1'b0;
                sweep_reg         <= '0;
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (face_we)
            begin
                face_count_reg <= face_count_reg + 1'b1;
            end
            if (cmd.adv_commit && !adv_ovf)
            begin
                vertex_base_reg <= adv_sum[VBW-1:0];
            end
            if (cmd.fetch_begin)
            begin
                drain_started_reg <= 1'b1;
            end
            if (cmd.load_head)
            begin
                entry_ok_reg    <= head_rdata_reg[HEW-1];
                drain_entry_reg <= head_rdata_reg[FW-1:0];
            end
            if (cmd.load_face)
            begin
                entry_ok_reg    <= face_rdata_reg[FEW-1];
                drain_entry_reg <= face_rdata_reg[LNK_LO +: FW];
            end
            if (cmd.drain_done)
            begin
                entry_ok_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        face_valid_next = 1'b0;
        vertex_a_next   = '0;
        vertex_b_next   = '0;
        vertex_c_next   = '0;
        texture_next    = '0;
        drained_next    = 1'b0;
        overflow_next   = 1'b0;
        case (cmd.emit)
            EMIT_INSERT:  overflow_next = ins_ovf;
            EMIT_ADVANCE: overflow_next = adv_ovf;
            EMIT_DRAINED: drained_next  = 1'b1;
            EMIT_FACE:
            begin
                face_valid_next = 1'b1;
                vertex_a_next   = face_rdata_reg[0 +: INDEX_W];
                vertex_b_next   = face_rdata_reg[INDEX_W +: INDEX_W];
                vertex_c_next   = face_rdata_reg[2 * INDEX_W +: INDEX_W];
                texture_next    = face_rdata_reg[HND_LO +: HANDLE_W];
            end
            default:
            begin
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        face_valid_reg <= face_valid_next;
        vertex_a_reg   <= vertex_a_next;
        vertex_b_reg   <= vertex_b_next;
        vertex_c_reg   <= vertex_c_next;
        texture_reg    <= texture_next;
        drained_reg    <= drained_next;
        overflow_reg   <= overflow_next;
    end

    assign status.drain_started = drain_started_reg;
    assign status.entry_ok      = entry_ok_reg;
    assign status.bucket_zero   = (drain_bucket_reg == '0);
    assign status.sweep_last    = (sweep_reg == BUCKET_TOP);
    assign status.face_textured = face_rdata_reg[TEX_BIT];

    assign done        = done_reg;
    assign face_valid  = face_valid_reg;
    assign vertex_a    = vertex_a_reg;
    assign vertex_b    = vertex_b_reg;
    assign vertex_c    = vertex_c_reg;
    assign texture_out = texture_reg;
    assign drained     = drained_reg;
    assign overflow    = overflow_reg;

endmodule
